/* rtl/core/sorted_distinct_value_counter_top_macros.svh */
// Assertion macros used by the controller RTL (sdvc_ctrl)
`ifndef SORTED_DISTINCT_VALUE_COUNTER_TOP_MACROS_SVH
`define SORTED_DISTINCT_VALUE_COUNTER_TOP_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define SDVC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define SDVC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/core/sdvc_pkg.sv */
//------------------------------------------------------------------------------
// sdvc_pkg
// Shared types and constants of the sorted distinct value counter.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package sdvc_pkg;

  localparam int unsigned Depth = 64;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam int unsigned ValW = 32;
  localparam int unsigned OccW = 7;
  localparam logic [OccW-1:0] OccMax = 7'd127;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [CntW-1:0] cnt_t;

  // Memory entry: value and its count.
  typedef struct packed {
    logic [ValW-1:0] value;
    logic [OccW-1:0] occ;
  } entry_t;

  // Memory access request.
  typedef struct packed {
    logic   re;
    addr_t  raddr;
    logic   we;
    addr_t  waddr;
    entry_t wdata;
  } mem_req_t;

endpackage

/* rtl/core/sdvc_store.sv */
//------------------------------------------------------------------------------
// sdvc_store
// Entry memory: one write port, one registered read port.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdvc_store (
  input  logic             clk_i,
  input  sdvc_pkg::mem_req_t req_i,
  output sdvc_pkg::entry_t rdata_o
);

  sdvc_pkg::entry_t mem_q [sdvc_pkg::Depth];
  sdvc_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/sdvc_ctrl.sv */
//------------------------------------------------------------------------------
// sdvc_ctrl
// Sequencer: searches, shifts and inserts entries, then emits the list.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sorted_distinct_value_counter_top_macros.svh"

module sdvc_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [31:0]       value_i,
  input  logic                     final_item_i,
  output sdvc_pkg::mem_req_t       req_o,
  input  sdvc_pkg::entry_t         rdata_i,
  output logic                     result_valid_o,
  output logic signed [31:0]       distinct_value_o,
  output logic [6:0]               occurrences_o,
  output logic                     run_end_o,
  output logic                     overflowed_o
);

  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StSearch = 6'b000010,
    StCheck  = 6'b000100,
    StShift  = 6'b001000,
    StEmitRd = 6'b010000,
    StEmit   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  sdvc_pkg::cnt_t used_q, used_d;
  sdvc_pkg::cnt_t idx_q, idx_d;
  logic ovf_q, ovf_d;
  logic fin_q, fin_d;
  logic [31:0] val_q, val_d;
  sdvc_pkg::entry_t carry_q, carry_d;

  logic rv_q, rv_d;
  logic [31:0] dv_q, dv_d;
  logic [6:0] oc_q, oc_d;
  logic re_q, re_d, ov_q, ov_d;

  logic less;
  assign less = $signed(rdata_i.value) < $signed(val_q);

  always_comb begin
    state_d = state_q;
    used_d = used_q;
    idx_d = idx_q;
    ovf_d = ovf_q;
    fin_d = fin_q;
    val_d = val_q;
    carry_d = carry_q;
    rv_d = 1'b0;
    dv_d = dv_q;
    oc_d = oc_q;
    re_d = re_q;
    ov_d = ov_q;
    req_o = '0;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          val_d = value_i;
          fin_d = final_item_i;
          idx_d = '0;
          if (used_q == '0) begin
            state_d = StShift;
            carry_d = '{value: value_i, occ: 7'd1};
          end else begin
            req_o.re = 1'b1;
            req_o.raddr = '0;
            state_d = StSearch;
          end
        end
      end
      StSearch: begin
        // rdata holds entry idx_q
        if (less) begin
          if (idx_q + 1'b1 == used_q) begin
            idx_d = used_q;
            state_d = StCheck;
          end else begin
            idx_d = idx_q + 1'b1;
            req_o.re = 1'b1;
            req_o.raddr = sdvc_pkg::AddrW'(idx_q + 1'b1);
          end
        end else if (rdata_i.value == val_q) begin
          req_o.we = rdata_i.occ != sdvc_pkg::OccMax;
          req_o.waddr = sdvc_pkg::AddrW'(idx_q);
          req_o.wdata = '{value: rdata_i.value, occ: rdata_i.occ + 7'd1};
          state_d = StCheck;
          idx_d = used_q + 1'b1; // marks: no insert
        end else begin
          state_d = StCheck;
          carry_d = '{value: val_q, occ: 7'd1};
          // insert at idx_q: first displaced is current rdata
          if (used_q == sdvc_pkg::CntW'(sdvc_pkg::Depth)) begin
            ovf_d = 1'b1;
            idx_d = used_q + 1'b1;
          end else begin
            req_o.we = 1'b1;
            req_o.waddr = sdvc_pkg::AddrW'(idx_q);
            req_o.wdata = carry_d;
            carry_d = rdata_i;
            idx_d = idx_q + 1'b1;
            used_d = used_q + 1'b1;
            if (idx_q + 1'b1 != used_q) begin
              req_o.re = 1'b1;
              req_o.raddr = sdvc_pkg::AddrW'(idx_q + 1'b1);
              state_d = StShift;
            end else begin
              state_d = StShift;
            end
          end
        end
      end
      StCheck: begin
        // append at end (idx==used) or done (idx>used)
        if (idx_q == used_q) begin
          if (used_q == sdvc_pkg::CntW'(sdvc_pkg::Depth)) begin
            ovf_d = 1'b1;
            idx_d = '0;
          end else begin
            req_o.we = 1'b1;
            req_o.waddr = sdvc_pkg::AddrW'(idx_q);
            req_o.wdata = '{value: val_q, occ: 7'd1};
            used_d = used_q + 1'b1;
          end
        end
        if (fin_q) begin
          state_d = StEmitRd;
        end else begin
          state_d = StIdle;
        end
        idx_d = '0;
      end
      StShift: begin
        // idx_q is next slot to fill with carry; rdata holds old entry idx_q
        // when idx_q < used_q-1 (count after the insert), else carry goes last.
        req_o.we = 1'b1;
        req_o.waddr = sdvc_pkg::AddrW'(idx_q);
        req_o.wdata = carry_q;
        if (idx_q + 1'b1 < used_q) begin
          carry_d = rdata_i;
          idx_d = idx_q + 1'b1;
          if (idx_q + 2'd2 < {1'b0, used_q}) begin
            req_o.re = 1'b1;
            req_o.raddr = sdvc_pkg::AddrW'(idx_q + 1'b1);
          end
        end else begin
          if (used_q == '0) begin
            used_d = sdvc_pkg::CntW'(1);
          end
          idx_d = '0;
          state_d = fin_q ? StEmitRd : StIdle;
        end
      end
      StEmitRd: begin
        req_o.re = 1'b1;
        req_o.raddr = sdvc_pkg::AddrW'(idx_q);
        state_d = StEmit;
      end
      StEmit: begin
        rv_d = 1'b1;
        dv_d = rdata_i.value;
        oc_d = (rdata_i.occ > 7'd1) ? rdata_i.occ : 7'd0;
        re_d = (idx_q + 1'b1 == used_q);
        ov_d = ovf_q;
        if (idx_q + 1'b1 == used_q) begin
          used_d = '0;
          ovf_d = 1'b0;
          idx_d = '0;
          state_d = StIdle;
        end else begin
          idx_d = idx_q + 1'b1;
          req_o.re = 1'b1;
          req_o.raddr = sdvc_pkg::AddrW'(idx_q + 1'b1);
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      used_q <= '0;
      idx_q <= '0;
      ovf_q <= 1'b0;
      rv_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q <= used_d;
      idx_q <= idx_d;
      ovf_q <= ovf_d;
      rv_q <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fin_q <= fin_d;
    val_q <= val_d;
    carry_q <= carry_d;
    dv_q <= dv_d;
    oc_q <= oc_d;
    re_q <= re_d;
    ov_q <= ov_d;
  end

  assign busy = (state_q != StIdle);
  assign result_valid_o = rv_q;
  assign distinct_value_o = dv_q;
  assign occurrences_o = oc_q;
  assign run_end_o = re_q;
  assign overflowed_o = ov_q;

  `SDVC_ASSERT_IMP(a_used_range, clk_i, rst_ni, 1'b1,
                   used_q <= sdvc_pkg::CntW'(sdvc_pkg::Depth))
  `SDVC_ASSERT_NXT(a_end_clears, clk_i, rst_ni, rv_q && re_q, used_q == '0)
  `SDVC_ASSERT_IMP(a_no_emit_idle, clk_i, rst_ni, start && !busy, !rv_q || re_q)

endmodule

/* rtl/core/sorted_distinct_value_counter_top.sv */
//------------------------------------------------------------------------------
// sorted_distinct_value_counter_top
// Keeps a sorted list of distinct values with counts; dumps it on the last item.
//------------------------------------------------------------------------------
// channel | signals                                   | direction
// item    | start, busy, value_i, final_item_i        | in
// result  | result_valid_o, distinct_value_o,
//         | occurrences_o, run_end_o, overflowed_o    | out, one cycle each
//
// An item scans the entry memory one entry per cycle through the registered
// read port up to its slot, then shifts the later entries up by one per cycle;
// busy stays high from the accepting edge until the item is stored.
// A final item then reads the first entry and emits one result per cycle.
// Reset clears the fill count; the memory needs no clearing.
// The receiver cannot stall; results are registered.
`timescale 1ns / 1ps

module sorted_distinct_value_counter_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] value_i,
  input  logic               final_item_i,
  output logic               result_valid_o,
  output logic signed [31:0] distinct_value_o,
  output logic [6:0]         occurrences_o,
  output logic               run_end_o,
  output logic               overflowed_o
);

  sdvc_pkg::mem_req_t req;
  sdvc_pkg::entry_t rdata;

  sdvc_store u_store (
    .clk_i   (clk_i),
    .req_i   (req),
    .rdata_o (rdata)
  );

  sdvc_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .value_i          (value_i),
    .final_item_i     (final_item_i),
    .req_o            (req),
    .rdata_i          (rdata),
    .result_valid_o   (result_valid_o),
    .distinct_value_o (distinct_value_o),
    .occurrences_o    (occurrences_o),
    .run_end_o        (run_end_o),
    .overflowed_o     (overflowed_o)
  );

endmodule

/* sim/sorted_distinct_value_counter_top_test.sv */
//------------------------------------------------------------------------------
// sorted_distinct_value_counter_top_test
// Sends sets of signed values and checks each dumped, sorted list of
// distinct values and counts against a predictor of the block's store.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_distinct_value_counter_top_test;

  localparam int unsigned StoreDepth = sdvc_pkg::Depth;
  localparam int unsigned CountSat = 127;

  // One item waiting to go out, plus how the driver should pace it.
  typedef struct {
    logic signed [31:0] value;
    logic               last;
    int unsigned        idle_pct;  // chance of an idle cycle before it
    bit                 drain;     // wait until all expected results are in
  } pending_item_t;

  // One predicted result of a list dump.
  typedef struct {
    logic signed [31:0] value;
    logic [6:0]         occ;
    logic               run_end;
    logic               ovf;
  } dump_entry_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic signed [31:0] value_i;
  logic               final_item_i;
  logic               result_valid_o;
  logic signed [31:0] distinct_value_o;
  logic [6:0]         occurrences_o;
  logic               run_end_o;
  logic               overflowed_o;

  pending_item_t send_q[$];
  dump_entry_t   dump_q[$];

  // Predicted store contents.
  logic signed [31:0] sorted_vals[StoreDepth];
  int unsigned        sorted_cnts[StoreDepth];
  int unsigned        fill;
  bit                 dropped;

  bit          item_taken;
  int unsigned items_sent;
  int unsigned sets_sent;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned cur_pct;
  bit          cur_drain;

  sorted_distinct_value_counter_top DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .value_i          (value_i),
    .final_item_i     (final_item_i),
    .result_valid_o   (result_valid_o),
    .distinct_value_o (distinct_value_o),
    .occurrences_o    (occurrences_o),
    .run_end_o        (run_end_o),
    .overflowed_o     (overflowed_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Insert one value into the predicted sorted list; on the last item of a
  // set, dump the list as expected results and clear it.
  task automatic store_value(input logic signed [31:0] v, input logic last);
    int unsigned pos;
    dump_entry_t e;
    begin
      pos = 0;
      while (pos < fill && sorted_vals[pos] < v) pos++;
      if (pos < fill && sorted_vals[pos] == v) begin
        if (sorted_cnts[pos] < CountSat) sorted_cnts[pos]++;
      end else if (fill >= StoreDepth) begin
        dropped = 1'b1;  // store full: new distinct value is lost
      end else begin
        for (int k = fill; k > pos; k--) begin
          sorted_vals[k] = sorted_vals[k-1];
          sorted_cnts[k] = sorted_cnts[k-1];
        end
        sorted_vals[pos] = v;
        sorted_cnts[pos] = 1;
        fill++;
      end
      if (last) begin
        for (int i = 0; i < fill; i++) begin
          e.value   = sorted_vals[i];
          e.occ     = (sorted_cnts[i] > 1) ? 7'(sorted_cnts[i]) : 7'd0;
          e.run_end = (i + 1 == fill);
          e.ovf     = dropped;
          dump_q = {dump_q, e};
        end
        fill = 0;
        dropped = 1'b0;
        sets_sent++;
      end
    end
  endtask

  // Monitor: take accepted items into the predictor, check each result.
  always @(posedge clk_i) begin
    dump_entry_t want;
    item_taken = 1'b0;
    if (rst_ni) begin
      if (start && !busy) begin
        item_taken = 1'b1;
        items_sent++;
        store_value(value_i, final_item_i);
      end
      if (result_valid_o) begin
        results_seen++;
        if (dump_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected result value=%0d occ=%0d end=%0b ovf=%0b",
                     distinct_value_o, occurrences_o, run_end_o, overflowed_o);
        end else begin
          want = dump_q.pop_front();
          if (distinct_value_o !== want.value || occurrences_o !== want.occ ||
              run_end_o !== want.run_end || overflowed_o !== want.ovf) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: result %0d exp value=%0d occ=%0d end=%0b ovf=%0b, got value=%0d occ=%0d end=%0b ovf=%0b",
                       results_seen, want.value, want.occ, want.run_end, want.ovf,
                       distinct_value_o, occurrences_o, run_end_o, overflowed_o);
          end
        end
      end
    end
  end

  // Driver: changes inputs on the falling edge, one assignment per signal.
  always @(negedge clk_i) begin
    bit present;
    pending_item_t nxt;
    present = 1'b0;
    if (rst_ni) begin
      if (start && item_taken) void'(send_q.pop_front());
      if (start && !item_taken) begin
        present = 1'b1;  // still waiting on busy: hold the item
      end else if (send_q.size() != 0) begin
        nxt = send_q[0];
        if (nxt.drain && dump_q.size() != 0) present = 1'b0;
        else present = ($urandom_range(99) >= nxt.idle_pct);
      end
    end
    if (present) begin
      nxt = send_q[0];
      value_i      <= nxt.value;
      final_item_i <= nxt.last;
    end
    start <= present;
  end

  task automatic queue_item(input logic signed [31:0] v, input logic last);
    pending_item_t p;
    begin
      p.value    = v;
      p.last     = last;
      p.idle_pct = cur_pct;
      p.drain    = cur_drain;
      cur_drain  = 1'b0;
      send_q = {send_q, p};
    end
  endtask

  // One random short set: half from a small range with repeats, half full-range.
  task automatic queue_random_set();
    int unsigned len;
    bit          wide;
    logic signed [31:0] v;
    begin
      len  = $urandom_range(1, 10);
      wide = $urandom_range(1);
      for (int i = 0; i < len; i++) begin
        v = wide ? $signed($urandom) : $signed(32'($urandom_range(0, 8)) - 32'sd4);
        queue_item(v, i == len - 1);
      end
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    value_i      = '0;
    final_item_i = 1'b0;
    item_taken   = 1'b0;
    items_sent   = 0;
    sets_sent    = 0;
    results_seen = 0;
    mismatches   = 0;
    fill         = 0;
    dropped      = 1'b0;
    cur_pct      = 0;
    cur_drain    = 1'b0;

    // Directed: single-item set, then extremes with repeats and signed order.
    queue_item(32'sd5, 1'b1);
    queue_item(32'sh7fffffff, 1'b0);
    queue_item(32'sh80000000, 1'b0);
    queue_item(32'sd0, 1'b0);
    queue_item(-32'sd1, 1'b0);
    queue_item(32'sd1, 1'b0);
    queue_item(32'sd0, 1'b0);
    queue_item(32'sh80000000, 1'b0);
    queue_item(32'sh7fffffff, 1'b1);
    // Final item repeating an earlier one.
    queue_item(32'sd3, 1'b0);
    queue_item(32'sd3, 1'b1);
    cur_drain = 1'b1;

    // Random sets in four pacing phases.
    for (int ph = 0; ph < 4; ph++) begin
      cur_pct = (ph == 1) ? 72 : (ph == 3) ? 26 : 0;
      for (int s = 0; s < 2; s++) queue_random_set();
      if (ph == 1) begin
        // Store overflow: more distinct values than entries, plus a repeat.
        for (int i = 0; i < StoreDepth + 2; i++) queue_item($signed($urandom), 1'b0);
        queue_item(32'sd0, 1'b0);
        queue_item(32'sd0, 1'b1);
      end
      if (ph == 2) begin
        // Count saturation on one value.
        for (int i = 0; i < CountSat + 2; i++) queue_item(-32'sd7, 1'b0);
        queue_item(32'sd9, 1'b1);
      end
      cur_drain = 1'b1;
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (send_q.size() != 0 || dump_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    if (dump_q.size() != 0) begin
      mismatches++;
      $display("ERROR: %0d results never arrived", dump_q.size());
    end
    $display("Sent %0d items in %0d sets (extremes, repeats, overflow, count limit);",
             items_sent, sets_sent);
    $display("checked %0d results, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("ERROR: timeout");
    $display("Simulation FAILED");
    $finish;
  end

endmodule
